### hdl/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, constants and helpers for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

	localparam int COORD_WIDTH = 12;
	localparam int CFG_WIDTH   = 12;
	localparam int IDX_WIDTH   = 2;
	localparam int SUM_WIDTH   = COORD_WIDTH + 2;

	localparam logic [IDX_WIDTH-1:0] REG_MAX_X = IDX_WIDTH'(0);
	localparam logic [IDX_WIDTH-1:0] REG_MAX_Y = IDX_WIDTH'(1);

	localparam logic [CFG_WIDTH-1:0]   MAX_X_RESET = CFG_WIDTH'(632);
	localparam logic [CFG_WIDTH-1:0]   MAX_Y_RESET = CFG_WIDTH'(472);
	localparam logic [COORD_WIDTH-1:0] POS_X_RESET = COORD_WIDTH'(320);
	localparam logic [COORD_WIDTH-1:0] POS_Y_RESET = COORD_WIDTH'(240);

	localparam int SYNC_BIT   = 3;
	localparam int X_SIGN_BIT = 4;
	localparam int Y_SIGN_BIT = 5;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_XBYTE  = 3'b010,
		PH_YBYTE  = 3'b100
	} phase_t;

	typedef struct packed {
		logic                   dropped;
		logic                   done;
		logic                   moved;
		logic [COORD_WIDTH-1:0] x;
		logic [COORD_WIDTH-1:0] y;
	} result_t;

	function automatic logic [COORD_WIDTH-1:0] clamp_coord(
		input logic signed [SUM_WIDTH-1:0] v,
		input logic [CFG_WIDTH-1:0]        lim_reg
	);
		logic [COORD_WIDTH-1:0] lim;
		lim = (lim_reg > CFG_WIDTH'({COORD_WIDTH{1'b1}})) ?
			{COORD_WIDTH{1'b1}} : COORD_WIDTH'(lim_reg);
		if (v < 0) begin
			return '0;
		end else if (v > $signed({2'b00, lim})) begin
			return lim;
		end else begin
			return v[COORD_WIDTH-1:0];
		end
	endfunction

endpackage

### hdl/ps2_mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Assembles three-byte mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_ready   rx_byte
//  result    out_valid / out_ready byte_dropped, packet_done, moved,
//                                  cursor_x, cursor_y
//  config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item is accepted per cycle unless a stalled result holds the pipeline;
// each accepted item passes through the input register and the result register.
// The update of phase and cursor between those registers is a single add and
// clamp per coordinate. Reset restores limits 632 and 472 and cursor 320, 240.
// A stalled result holds the result register; the input register keeps
// accepting while the result register is free or being taken.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              byte_dropped,
	output logic                              packet_done,
	output logic                              moved,
	output logic [ps2mt_pkg::COORD_WIDTH-1:0] cursor_x,
	output logic [ps2mt_pkg::COORD_WIDTH-1:0] cursor_y,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ps2mt_pkg::IDX_WIDTH-1:0]   cfg_index,
	input  logic [ps2mt_pkg::CFG_WIDTH-1:0]   cfg_data
);
	import ps2mt_pkg::*;

	logic                 valid_s1, valid_s2;
	logic [7:0]           byte_s1;
	result_t              result_s2;
	result_t              core_result;
	logic                 advance;
	logic [CFG_WIDTH-1:0] max_x_q, max_y_q;

	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= MAX_X_RESET;
			max_y_q <= MAX_Y_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MAX_X) begin
				max_x_q <= cfg_data;
			end else if (cfg_index == REG_MAX_Y) begin
				max_y_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (valid_s1 && advance) begin
			result_s2 <= core_result;
		end
	end

	ps2mt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.max_x   (max_x_q),
		.max_y   (max_y_q),
		.result  (core_result)
	);

	assign out_valid    = valid_s2;
	assign byte_dropped = result_s2.dropped;
	assign packet_done  = result_s2.done;
	assign moved        = result_s2.moved;
	assign cursor_x     = result_s2.x;
	assign cursor_y     = result_s2.y;

endmodule

### hdl/ps2mt_core.sv
// ----------------------------------------------------------------------------
// ps2mt_core
// Packet phase tracking, packet byte storage and cursor update with clamping.
// ----------------------------------------------------------------------------
module ps2mt_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   rx_byte,
	input  logic [ps2mt_pkg::CFG_WIDTH-1:0] max_x,
	input  logic [ps2mt_pkg::CFG_WIDTH-1:0] max_y,
	output ps2mt_pkg::result_t           result
);
	import ps2mt_pkg::*;

	phase_t                  phase_q, phase_d;
	logic [7:0]              header_q;
	logic [7:0]              xbyte_q;
	logic [COORD_WIDTH-1:0]  pos_x_q, pos_y_q;
	logic [COORD_WIDTH-1:0]  new_x, new_y;
	logic signed [8:0]       dx, dy;
	logic signed [SUM_WIDTH-1:0] sum_x, sum_y;

	always_comb begin
		dx    = $signed({header_q[X_SIGN_BIT], xbyte_q});
		dy    = $signed({header_q[Y_SIGN_BIT], rx_byte});
		sum_x = $signed({2'b00, pos_x_q}) + SUM_WIDTH'(dx);
		sum_y = $signed({2'b00, pos_y_q}) - SUM_WIDTH'(dy);
		new_x = clamp_coord(sum_x, max_x);
		new_y = clamp_coord(sum_y, max_y);
	end

	always_comb begin
		result.dropped = 1'b0;
		result.done    = 1'b0;
		result.moved   = 1'b0;
		result.x       = pos_x_q;
		result.y       = pos_y_q;
		phase_d        = phase_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (rx_byte[SYNC_BIT]) begin
					phase_d = PH_XBYTE;
				end else begin
					result.dropped = 1'b1;
				end
			end
			PH_XBYTE: begin
				phase_d = PH_YBYTE;
			end
			default: begin
				result.done  = 1'b1;
				result.moved = (dx != 9'sd0) || (dy != 9'sd0);
				result.x     = new_x;
				result.y     = new_y;
				phase_d      = PH_HEADER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_x_q <= POS_X_RESET;
			pos_y_q <= POS_Y_RESET;
		end else if (step) begin
			phase_q <= phase_d;
			pos_x_q <= result.x;
			pos_y_q <= result.y;
		end
	end

	always_ff @(posedge clk) begin
		if (step && phase_q == PH_HEADER) begin
			header_q <= rx_byte;
		end
		if (step && phase_q == PH_XBYTE) begin
			xbyte_q <= rx_byte;
		end
	end

	a_drop_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_HEADER && !rx_byte[SYNC_BIT] |=> phase_q == PH_HEADER)
		else $error("phase left header on a dropped item");

	a_packet_returns: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_YBYTE |=> phase_q == PH_HEADER)
		else $error("phase did not return to header after a packet");

	a_clamp_x: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_YBYTE |=> pos_x_q <= $past(max_x))
		else $error("cursor column above its limit after a packet");

	a_moved_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.moved |-> result.done && !result.dropped)
		else $error("movement flagged without a completed packet");

endmodule

### tb/sv/ps2_mouse_packet_cursor_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_test
// Feeds mouse bytes through the packet tracker with random gaps and stalls on
// both channels, predicts each report from its own copy of the packet phase,
// cursor and limits, and compares every report field by field. Directed
// bytes, limit extremes and long random packet streams with noise are run.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_test;
	import ps2mt_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES   = 165;

	localparam logic [IDX_WIDTH-1:0] REG_SPARE_2 = IDX_WIDTH'(2);
	localparam logic [IDX_WIDTH-1:0] REG_SPARE_3 = IDX_WIDTH'(3);

	typedef enum int {PACE_NONE, PACE_FULL, PACE_MIXED} pace_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [7:0]             rx_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic                   byte_dropped;
	logic                   packet_done;
	logic                   moved;
	logic [COORD_WIDTH-1:0] cursor_x;
	logic [COORD_WIDTH-1:0] cursor_y;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_WIDTH-1:0]   cfg_index;
	logic [CFG_WIDTH-1:0]   cfg_data;

	phase_t                 pkt_phase;
	logic [7:0]             pkt_header;
	logic [7:0]             pkt_xbyte;
	logic [COORD_WIDTH-1:0] track_x;
	logic [COORD_WIDTH-1:0] track_y;
	logic [CFG_WIDTH-1:0]   limit_x;
	logic [CFG_WIDTH-1:0]   limit_y;

	result_t pending_reports [$];
	pace_t   send_pace;
	pace_t   take_pace;
	int      mismatches;
	int      bytes_sent;
	int      bytes_used;
	int      drops_seen;
	int      packets_seen;
	int      reports_checked;
	int      cfg_writes;
	int      cycles;

	ps2_mouse_packet_cursor_tracker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.byte_dropped(byte_dropped),
		.packet_done(packet_done),
		.moved(moved),
		.cursor_x(cursor_x),
		.cursor_y(cursor_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int draw_wait(pace_t p);
		case (p)
			PACE_NONE: return 0;
			PACE_FULL: return $urandom_range(0, 19);
			default:   return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
		endcase
	endfunction

	function automatic logic [COORD_WIDTH-1:0] bound_coord(int v, logic [CFG_WIDTH-1:0] lim_reg);
		int top;
		top = (1 << COORD_WIDTH) - 1;
		if (int'(lim_reg) < top) top = int'(lim_reg);
		if (v < 0) return '0;
		if (v > top) return COORD_WIDTH'(top);
		return COORD_WIDTH'(v);
	endfunction

	function automatic result_t track_byte(logic [7:0] b);
		result_t r;
		int      dx;
		int      dy;
		r = '0;
		case (pkt_phase)
			PH_HEADER: begin
				if (!b[SYNC_BIT]) begin
					r.dropped = 1'b1;
				end else begin
					pkt_header = b;
					pkt_phase  = PH_XBYTE;
				end
			end
			PH_XBYTE: begin
				pkt_xbyte = b;
				pkt_phase = PH_YBYTE;
			end
			default: begin
				dx = pkt_header[X_SIGN_BIT] ? int'(pkt_xbyte) - 256 : int'(pkt_xbyte);
				dy = pkt_header[Y_SIGN_BIT] ? int'(b) - 256 : int'(b);
				track_x = bound_coord(int'(track_x) + dx, limit_x);
				track_y = bound_coord(int'(track_y) - dy, limit_y);
				r.done  = 1'b1;
				r.moved = (dx != 0) || (dy != 0);
				pkt_phase = PH_HEADER;
			end
		endcase
		r.x = track_x;
		r.y = track_y;
		return r;
	endfunction

	function automatic void compare_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int      gap;
		result_t r;
		gap = draw_wait(send_pace);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		r = track_byte(b);
		pending_reports.push_back(r);
		bytes_sent++;
		if (r.dropped) drops_seen++;
		else bytes_used++;
		if (r.done) packets_seen++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input int value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_WIDTH'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MAX_X: limit_x = CFG_WIDTH'(value);
			REG_MAX_Y: limit_y = CFG_WIDTH'(value);
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic send_packet(input bit steer, input logic [1:0] dir, input bit tiny);
		logic [7:0] hdr;
		logic [7:0] xb;
		logic [7:0] yb;
		hdr = 8'($urandom);
		hdr[SYNC_BIT] = 1'b1;
		if (steer) {hdr[Y_SIGN_BIT], hdr[X_SIGN_BIT]} = dir;
		xb = tiny ? 8'($urandom_range(0, 1)) : 8'($urandom);
		yb = tiny ? 8'($urandom_range(0, 1)) : 8'($urandom);
		send_byte(hdr);
		send_byte(xb);
		send_byte(yb);
	endtask

	task automatic test_directed_bytes();
		logic [7:0] seq [$];
		seq = '{8'h00, 8'hF7,
			8'h08, 8'h00, 8'h00,
			8'h08, 8'hFF, 8'h00,
			8'h18, 8'h00, 8'h00,
			8'h28, 8'h00, 8'h00,
			8'h08, 8'h00, 8'hFF,
			8'hFF, 8'hFF, 8'hFF,
			8'h08, 8'hFF, 8'h00,
			8'h08, 8'hFF, 8'h00};
		send_pace = PACE_MIXED;
		take_pace = PACE_MIXED;
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	task automatic test_limit_extremes();
		send_pace = PACE_FULL;
		take_pace = PACE_NONE;
		write_reg(REG_MAX_X, 0);
		write_reg(REG_MAX_Y, 0);
		send_byte(8'h08);
		send_byte(8'h05);
		send_byte(8'h05);
		send_byte(8'h38);
		send_byte(8'h80);
		send_byte(8'h80);
		write_reg(REG_MAX_X, 4095);
		write_reg(REG_MAX_Y, 4095);
		repeat (18) begin
			send_byte(8'h28);
			send_byte(8'hFF);
			send_byte(8'h00);
		end
		write_reg(REG_SPARE_2, 0);
		write_reg(REG_SPARE_3, 0);
		send_byte(8'h08);
		send_byte(8'h00);
		send_byte(8'h00);
		// The limits drop below the cursor in the middle of a packet.
		send_byte(8'h08);
		write_reg(REG_MAX_X, 100);
		write_reg(REG_MAX_Y, 50);
		send_byte(8'h00);
		send_byte(8'h00);
	endtask

	task automatic test_random_traffic();
		int         stop_at;
		logic [1:0] dir;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_MAX_X, MAX_X_RESET);
					write_reg(REG_MAX_Y, MAX_Y_RESET);
				end
				2: begin
					write_reg(REG_MAX_X, 4095);
					write_reg(REG_MAX_Y, 4095);
				end
				3: begin
					write_reg(REG_MAX_X, $urandom_range(0, 15));
					write_reg(REG_MAX_Y, $urandom_range(0, 15));
				end
				4: begin
					write_reg(REG_MAX_X, 0);
					write_reg(REG_MAX_Y, 4095);
				end
				5: begin
					write_reg(REG_MAX_X, 4095);
					write_reg(REG_MAX_Y, 0);
				end
				default: begin
					write_reg(REG_MAX_X, $urandom_range(0, 4095));
					write_reg(REG_MAX_Y, $urandom_range(0, 4095));
				end
			endcase
			send_pace = pace_t'(ph % 3);
			take_pace = pace_t'((ph + 1) % 3);
			dir = 2'($urandom);
			stop_at = bytes_used + PHASE_BYTES;
			while (bytes_used < stop_at) begin
				if ($urandom_range(0, 9) == 0) begin
					send_byte(8'($urandom));
				end else begin
					send_packet($urandom_range(0, 2) == 0, dir, $urandom_range(0, 5) == 0);
				end
			end
		end
	endtask

	initial begin
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = draw_wait(take_pace);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_reports
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected report, actual dropped %0b done %0b moved %0b x %0d y %0d",
					$time, byte_dropped, packet_done, moved, cursor_x, cursor_y);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				compare_field("byte_dropped", want.dropped, byte_dropped);
				compare_field("packet_done", want.done, packet_done);
				compare_field("moved", want.moved, moved);
				compare_field("cursor_x", want.x, cursor_x);
				compare_field("cursor_y", want.y, cursor_y);
				reports_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d reports outstanding", $time, pending_reports.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MAX_X;
		cfg_data  = '0;
		pkt_phase  = PH_HEADER;
		pkt_header = '0;
		pkt_xbyte  = '0;
		track_x    = POS_X_RESET;
		track_y    = POS_Y_RESET;
		limit_x    = MAX_X_RESET;
		limit_y    = MAX_Y_RESET;
		send_pace  = PACE_MIXED;
		take_pace  = PACE_MIXED;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_bytes();
		test_limit_extremes();
		test_random_traffic();
		drain();
		$display("Sent %0d bytes: %0d packets completed, %0d bytes dropped for missing sync.",
			bytes_sent, packets_seen, drops_seen);
		$display("Checked %0d reports over %0d register writes, limits from 0 to 4095.",
			reports_checked, cfg_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
